@@ rtl/glyph_text_console_renderer_assert.svh @@
// Assertion macros for the text console renderer.
`ifndef GLYPH_TEXT_CONSOLE_RENDERER_ASSERT_SVH
`define GLYPH_TEXT_CONSOLE_RENDERER_ASSERT_SVH

// Property checked on every rising clock edge outside reset.
`define GTCR_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition that must never be true outside reset.
`define GTCR_NEVER(name, cond, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

@@ rtl/gtcr_pkg.sv @@
// Shared types and constants of the text console renderer.
package gtcr_pkg;

	localparam logic [1:0] ACT_PUT  = 2'd0;
	localparam logic [1:0] ACT_LOAD = 2'd1;
	localparam logic [1:0] ACT_HOME = 2'd2;

	localparam logic [7:0] CODE_NEWLINE   = 8'h0A;
	localparam logic [7:0] CODE_BACKSPACE = 8'h08;
	localparam logic [31:0] COLOR_BLACK   = 32'h0000_0000;
	localparam logic [7:0] MASK_FULL      = 8'hFF;

	localparam int ROW_LIMIT = 255;
	localparam int SLOT_ROWS = 16;
	localparam int Q_DEPTH   = 4;
	localparam int Q_AW      = 2;
	localparam int MEM_DEPTH = 4096;

	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_DRAW = 1'b1
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [7:0]  code;
		logic [3:0]  load_row;
		logic [7:0]  load_bits;
		logic        blank;
		logic [7:0]  edge_mask;
		logic [9:0]  x;
		logic [11:0] base_y;
		logic [31:0] color;
	} entry_t;

endpackage

@@ rtl/gtcr_in_if.sv @@
// Request channel carrying console actions.
interface gtcr_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] action;
	logic [7:0] char_code;
	logic [3:0] glyph_row;
	logic [7:0] glyph_bits;

	modport source (output valid, action, char_code, glyph_row, glyph_bits, input ready);
	modport sink (input valid, action, char_code, glyph_row, glyph_bits, output ready);
endinterface

@@ rtl/gtcr_out_if.sv @@
// Request channel carrying glyph row writes.
interface gtcr_out_if;
	logic        valid;
	logic        ready;
	logic [9:0]  pixel_x;
	logic [9:0]  pixel_y;
	logic [7:0]  pixel_mask;
	logic [31:0] pixel_color;
	logic        last_row;

	modport source (output valid, pixel_x, pixel_y, pixel_mask, pixel_color, last_row,
		input ready);
	modport sink (input valid, pixel_x, pixel_y, pixel_mask, pixel_color, last_row,
		output ready);
endinterface

@@ rtl/gtcr_front.sv @@
// Front end: takes requests, tracks the cursor and builds queue entries.
module gtcr_front
	import gtcr_pkg::*;
#(
	parameter int COLUMNS       = 128,
	parameter int GLYPH_HEIGHT  = 16,
	parameter int SCREEN_HEIGHT = 768,
	parameter int SCREEN_WIDTH  = 1024
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          text_color_we,
	input  logic [31:0]   text_color,
	gtcr_in_if.sink       in,
	output logic          push,
	output entry_t        push_entry,
	input  logic          full
);

	localparam logic [7:0]  COLS_W = 8'(COLUMNS);
	localparam logic [10:0] SW_W   = 11'(SCREEN_WIDTH);
	localparam logic [11:0] SH_W   = 12'(SCREEN_HEIGHT);
	localparam logic [11:0] GH_W   = 12'(GLYPH_HEIGHT);
	localparam logic [7:0]  ROW_MAX = 8'(ROW_LIMIT);

	logic [31:0] color_q;
	logic [6:0]  col_q;
	logic [7:0]  row_q;

	logic        acc;
	logic        is_nl;
	logic        is_bs;
	logic [6:0]  cell_col;
	logic [9:0]  cell_x;
	logic [11:0] cell_y;
	logic [10:0] room;
	logic        visible;
	logic [7:0]  emask;
	logic [6:0]  col_d;
	logic [7:0]  row_d;
	logic [7:0]  col_inc;
	logic [7:0]  row_inc;

	assign in.ready = !full;
	assign acc      = in.valid && in.ready;
	assign is_nl    = in.char_code == CODE_NEWLINE;
	assign is_bs    = in.char_code == CODE_BACKSPACE;
	assign row_inc  = (row_q < ROW_MAX) ? row_q + 8'd1 : row_q;

	always_comb begin
		cell_col = col_q;
		if (is_bs && col_q != 7'd0) begin
			cell_col = col_q - 7'd1;
		end
		cell_x  = {cell_col, 3'b000};
		cell_y  = 12'(row_q) * GH_W;
		room    = SW_W - {1'b0, cell_x};
		visible = ({1'b0, cell_x} < SW_W) && (cell_y < SH_W);
		emask   = MASK_FULL;
		if (visible && room < 11'd8) begin
			emask = MASK_FULL << (4'd8 - room[3:0]);
		end
	end

	always_comb begin
		col_d   = col_q;
		row_d   = row_q;
		col_inc = {1'b0, col_q} + 8'd1;
		if (in.action == ACT_HOME) begin
			col_d = 7'd0;
			row_d = 8'd0;
		end else if (in.action == ACT_PUT) begin
			if (is_nl) begin
				col_d = 7'd0;
				row_d = row_inc;
			end else if (is_bs) begin
				col_d = cell_col;
			end else if (col_inc >= COLS_W) begin
				col_d = 7'd0;
				row_d = row_inc;
			end else begin
				col_d = col_inc[6:0];
			end
		end
	end

	always_comb begin
		push_entry.op        = (in.action == ACT_LOAD) ? OP_LOAD : OP_DRAW;
		push_entry.code      = in.char_code;
		push_entry.load_row  = in.glyph_row;
		push_entry.load_bits = in.glyph_bits;
		push_entry.blank     = is_bs;
		push_entry.edge_mask = emask;
		push_entry.x         = cell_x;
		push_entry.base_y    = cell_y;
		push_entry.color     = is_bs ? COLOR_BLACK : color_q;
		push = acc && ((in.action == ACT_LOAD) ||
			(in.action == ACT_PUT && !is_nl && visible));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_q <= 32'hFFFF_FFFF;
			col_q   <= 7'd0;
			row_q   <= 8'd0;
		end else begin
			if (text_color_we) begin
				color_q <= text_color;
			end
			if (acc) begin
				col_q <= col_d;
				row_q <= row_d;
			end
		end
	end

endmodule

@@ rtl/gtcr_fifo.sv @@
// Short entry queue between front and back end.
module gtcr_fifo
	import gtcr_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_entry,
	output logic   full,
	input  logic   pop,
	output logic   head_valid,
	output entry_t head
);

	entry_t          slot_q [Q_DEPTH];
	logic [Q_AW-1:0] wr_q;
	logic [Q_AW-1:0] rd_q;
	logic [Q_AW:0]   cnt_q;

	assign full       = cnt_q == (Q_AW+1)'(Q_DEPTH);
	assign head_valid = cnt_q != '0;
	assign head       = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

@@ rtl/gtcr_back.sv @@
// Back end: glyph memory and row write sequencer.
module gtcr_back
	import gtcr_pkg::*;
#(
	parameter int GLYPH_HEIGHT  = 16,
	parameter int SCREEN_HEIGHT = 768
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      head_valid,
	input  entry_t    head,
	output logic      pop,
	gtcr_out_if.source out
);

	`include "glyph_text_console_renderer_assert.svh"

	localparam logic [3:0]  LAST_ROW = 4'(GLYPH_HEIGHT - 1);
	localparam logic [12:0] SH_W     = 13'(SCREEN_HEIGHT);

	logic [7:0]  mem [MEM_DEPTH];

	entry_t      cur_q;
	logic        busy_q;
	logic [3:0]  row_q;

	logic        v_s2;
	logic [9:0]  x_s2;
	logic [9:0]  y_s2;
	logic [7:0]  emask_s2;
	logic        blank_s2;
	logic [31:0] color_s2;
	logic        last_s2;
	logic [7:0]  rdata_s2;

	logic        adv;
	logic        issue;
	logic        is_last;
	logic        last_issue;
	logic        can_take;
	logic        load_we;
	logic [11:0] yi;

	assign adv        = !v_s2 || out.ready;
	assign issue      = busy_q && adv;
	assign yi         = cur_q.base_y + 12'(row_q);
	assign is_last    = (row_q == LAST_ROW) || ({1'b0, yi} + 13'd1 >= SH_W);
	assign last_issue = issue && is_last;
	assign can_take   = !busy_q || last_issue;
	assign pop        = head_valid && can_take;
	assign load_we    = pop && head.op == OP_LOAD;

	assign out.valid       = v_s2;
	assign out.pixel_x     = x_s2;
	assign out.pixel_y     = y_s2;
	assign out.pixel_mask  = blank_s2 ? emask_s2 : (rdata_s2 & emask_s2);
	assign out.pixel_color = color_s2;
	assign out.last_row    = last_s2;

	always_ff @(posedge clk) begin
		if (load_we) begin
			mem[{head.code, head.load_row}] <= head.load_bits;
		end
		if (issue) begin
			rdata_s2 <= mem[{cur_q.code, row_q}];
			x_s2     <= cur_q.x;
			y_s2     <= yi[9:0];
			emask_s2 <= cur_q.edge_mask;
			blank_s2 <= cur_q.blank;
			color_s2 <= cur_q.color;
			last_s2  <= is_last;
		end
		if (pop) begin
			cur_q <= head;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			row_q  <= '0;
			v_s2   <= 1'b0;
		end else begin
			if (pop) begin
				busy_q <= head.op == OP_DRAW;
				row_q  <= '0;
			end else if (last_issue) begin
				busy_q <= 1'b0;
			end else if (issue) begin
				row_q <= row_q + 4'd1;
			end
			if (adv) begin
				v_s2 <= issue;
			end
		end
	end

	`GTCR_ASSERT(a_row_bound, busy_q |-> row_q <= LAST_ROW, "row counter past glyph height")
	`GTCR_ASSERT(a_done, last_issue && !pop |=> !busy_q, "sequencer busy after last row")
	`GTCR_ASSERT(a_hold, v_s2 && !out.ready |=> $stable(rdata_s2) && $stable(y_s2), "stalled row lost")
	`GTCR_NEVER(a_load_busy, load_we && busy_q && !last_issue, "glyph load during drawing")

endmodule

@@ rtl/glyph_text_console_renderer.sv @@
// Top level of the 8x16 bitmap font text console renderer.
//
//   channel   dir  handshake            payload
//   in        in   in.valid/in.ready    action, char_code, glyph_row, glyph_bits
//   out       out  out.valid/out.ready  pixel_x, pixel_y, pixel_mask, pixel_color, last_row
//   cfg       in   text_color_we        text_color
//
// Printed characters and backspaces give one row write per cycle while the output does not
// stall, GLYPH_HEIGHT row writes each (fewer when clipped at the screen bottom).
// Loads, home, newline and off-screen cells give no row write; loads are queued for the back end.
// A four-entry queue separates request intake from row generation; output stalls
// hold the sequencer, and intake stops only when the queue is full.
// Reset clears cursor, queue and sequencer; glyph memory is not cleared.
module glyph_text_console_renderer
	import gtcr_pkg::*;
#(
	parameter int COLUMNS       = 128,
	parameter int GLYPH_HEIGHT  = 16,
	parameter int SCREEN_HEIGHT = 768,
	parameter int SCREEN_WIDTH  = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        text_color_we,
	input  logic [31:0] text_color,
	gtcr_in_if.sink     in,
	gtcr_out_if.source  out
);

	logic   push;
	entry_t push_entry;
	logic   full;
	logic   pop;
	logic   head_valid;
	entry_t head;

	gtcr_front #(
		.COLUMNS       (COLUMNS),
		.GLYPH_HEIGHT  (GLYPH_HEIGHT),
		.SCREEN_HEIGHT (SCREEN_HEIGHT),
		.SCREEN_WIDTH  (SCREEN_WIDTH)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.text_color_we (text_color_we),
		.text_color    (text_color),
		.in            (in),
		.push          (push),
		.push_entry    (push_entry),
		.full          (full)
	);

	gtcr_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	gtcr_back #(
		.GLYPH_HEIGHT  (GLYPH_HEIGHT),
		.SCREEN_HEIGHT (SCREEN_HEIGHT)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.out        (out)
	);

endmodule

@@ tb/glyph_text_console_renderer_tb.sv @@
// Self-checking testbench for the text console renderer: queued requests, predicted row writes.
module glyph_text_console_renderer_tb;
	import gtcr_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int COLUMNS       = 128;
	localparam int GLYPH_HEIGHT  = 16;
	localparam int SCREEN_HEIGHT = 768;
	localparam int SCREEN_WIDTH  = 1024;
	localparam int CELL_W        = 8;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int SETTLE_CYCLES = 48;

	localparam logic [1:0] ACT_NONE = 2'd3;

	typedef struct packed {
		logic [1:0] action;
		logic [7:0] char_code;
		logic [3:0] glyph_row;
		logic [7:0] glyph_bits;
	} console_req_t;

	typedef struct packed {
		logic [9:0]  x;
		logic [9:0]  y;
		logic [7:0]  mask;
		logic [31:0] color;
		logic        last;
	} row_write_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        text_color_we;
	logic [31:0] text_color;

	gtcr_in_if  req_if ();
	gtcr_out_if wr_if ();

	glyph_text_console_renderer #(
		.COLUMNS      (COLUMNS),
		.GLYPH_HEIGHT (GLYPH_HEIGHT),
		.SCREEN_HEIGHT(SCREEN_HEIGHT),
		.SCREEN_WIDTH (SCREEN_WIDTH)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.text_color_we(text_color_we),
		.text_color   (text_color),
		.in           (req_if),
		.out          (wr_if)
	);

	always #4 clk = ~clk;

	console_req_t pending_q[$];
	row_write_t   row_writes_q[$];
	console_req_t shown_req;

	logic [7:0]  font_mem [0:MEM_DEPTH-1];
	int          pred_col = 0;
	int          pred_row = 0;
	logic [31:0] pred_color;

	logic [15:0] gen_rows [0:255];
	int          loaded_codes[$];
	int          queued_cnt;

	int send_idle_pct;
	int recv_stall_pct;
	int error_cnt = 0;
	int cycle_cnt = 0;

	function automatic void advance_line();
		pred_col = 0;
		if (pred_row < ROW_LIMIT)
			pred_row++;
	endfunction

	function automatic string fmt_row(input row_write_t w);
		return $sformatf("x=%0d y=%0d mask=%02h color=%08h last=%0b",
			w.x, w.y, w.mask, w.color, w.last);
	endfunction

	task automatic draw_cell(input bit blank, input logic [7:0] code, input logic [31:0] color);
		int         x;
		int         top;
		int         visible;
		logic [7:0] edge_mask;
		row_write_t w;
		x = pred_col * CELL_W;
		top = pred_row * GLYPH_HEIGHT;
		visible = (SCREEN_HEIGHT - top < GLYPH_HEIGHT) ? SCREEN_HEIGHT - top : GLYPH_HEIGHT;
		if (visible > SLOT_ROWS)
			visible = SLOT_ROWS;
		if (x >= SCREEN_WIDTH || visible <= 0)
			return;
		if (x + CELL_W > SCREEN_WIDTH)
			edge_mask = 8'(8'hFF << (CELL_W - (SCREEN_WIDTH - x)));
		else
			edge_mask = MASK_FULL;
		for (int i = 0; i < visible; i++) begin
			w.x = 10'(x);
			w.y = 10'(top + i);
			w.mask = (blank ? MASK_FULL : font_mem[{code, 4'(i)}]) & edge_mask;
			w.color = color;
			w.last = (i == visible - 1);
			row_writes_q.push_back(w);
		end
	endtask

	task automatic render_request(input console_req_t r);
		case (r.action)
			ACT_LOAD: font_mem[{r.char_code, r.glyph_row}] = r.glyph_bits;
			ACT_HOME: begin
				pred_col = 0;
				pred_row = 0;
			end
			ACT_PUT: begin
				if (r.char_code == CODE_NEWLINE) begin
					advance_line();
				end else if (r.char_code == CODE_BACKSPACE) begin
					if (pred_col > 0)
						pred_col--;
					draw_cell(1'b1, 8'h00, COLOR_BLACK);
				end else begin
					draw_cell(1'b0, r.char_code, pred_color);
					pred_col = (pred_col + 1) & 8'hFF;
				end
				if (pred_col >= COLUMNS)
					advance_line();
			end
			default: ;
		endcase
	endtask

	task automatic queue_req(input logic [1:0] action, input logic [7:0] code,
			input logic [3:0] row, input logic [7:0] bits);
		pending_q.push_back('{action, code, row, bits});
		queued_cnt++;
		if (action == ACT_LOAD && gen_rows[code] != 16'hFFFF) begin
			gen_rows[code][row] = 1'b1;
			if (gen_rows[code] == 16'hFFFF)
				loaded_codes.push_back(code);
		end
	endtask

	task automatic queue_glyph(input logic [7:0] code);
		for (int row = 0; row < SLOT_ROWS; row++)
			queue_req(ACT_LOAD, code, 4'(row), 8'($urandom_range(255)));
	endtask

	function automatic logic [7:0] pick_printable();
		return 8'(loaded_codes[$urandom_range(loaded_codes.size() - 1)]);
	endfunction

	task automatic queue_print();
		queue_req(ACT_PUT, pick_printable(), 4'($urandom_range(15)), 8'($urandom_range(255)));
	endtask

	task automatic queue_traffic(input int count);
		int target;
		int r;
		int word_len;
		target = queued_cnt + count;
		while (queued_cnt < target) begin
			r = $urandom_range(99);
			if (r < 8) begin
				queue_glyph(8'($urandom_range(255)));
			end else if (r < 16) begin
				queue_req(ACT_LOAD, 8'($urandom_range(255)), 4'($urandom_range(15)),
					8'($urandom_range(255)));
			end else if (r < 55) begin
				queue_print();
			end else if (r < 65) begin
				queue_req(ACT_PUT, CODE_BACKSPACE, 4'($urandom_range(15)),
					8'($urandom_range(255)));
			end else if (r < 74) begin
				queue_req(ACT_PUT, CODE_NEWLINE, 4'($urandom_range(15)),
					8'($urandom_range(255)));
			end else if (r < 79) begin
				queue_req(ACT_HOME, 8'($urandom_range(255)), 4'($urandom_range(15)),
					8'($urandom_range(255)));
			end else if (r < 84) begin
				queue_req(ACT_NONE, 8'($urandom_range(255)), 4'($urandom_range(15)),
					8'($urandom_range(255)));
			end else begin
				word_len = $urandom_range(3, 10);
				repeat (word_len)
					queue_print();
				queue_req(ACT_PUT, CODE_NEWLINE, 4'($urandom_range(15)),
					8'($urandom_range(255)));
			end
		end
	endtask

	task automatic wait_drained();
		while (pending_q.size() != 0 || req_if.valid || row_writes_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	task automatic write_color(input logic [31:0] value);
		@(posedge clk);
		text_color_we <= 1'b1;
		text_color <= value;
		pred_color = value;
		@(posedge clk);
		text_color_we <= 1'b0;
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		console_req_t nxt;
		if (!arst_n) begin
			req_if.valid <= 1'b0;
			req_if.action <= ACT_PUT;
			req_if.char_code <= 8'h00;
			req_if.glyph_row <= 4'h0;
			req_if.glyph_bits <= 8'h00;
		end else begin
			if (req_if.valid && req_if.ready)
				render_request(shown_req);
			if (!req_if.valid || req_if.ready) begin
				if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					nxt = pending_q.pop_front();
					shown_req = nxt;
					req_if.valid <= 1'b1;
					req_if.action <= nxt.action;
					req_if.char_code <= nxt.char_code;
					req_if.glyph_row <= nxt.glyph_row;
					req_if.glyph_bits <= nxt.glyph_bits;
				end else begin
					req_if.valid <= 1'b0;
				end
			end
		end
	end

	// row write monitor
	always @(posedge clk or negedge arst_n) begin
		row_write_t got;
		row_write_t want;
		if (!arst_n) begin
			wr_if.ready <= 1'b0;
		end else begin
			if (wr_if.valid && wr_if.ready) begin
				got = {wr_if.pixel_x, wr_if.pixel_y, wr_if.pixel_mask, wr_if.pixel_color,
					wr_if.last_row};
				if (row_writes_q.size() == 0) begin
					$display("%0t: unexpected row write %s", $time, fmt_row(got));
					error_cnt++;
				end else begin
					want = row_writes_q.pop_front();
					if (got !== want) begin
						$display("%0t: row write mismatch: expected %s, got %s",
							$time, fmt_row(want), fmt_row(got));
						error_cnt++;
					end
				end
			end
			wr_if.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d row writes outstanding", $time, row_writes_q.size());
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		logic [7:0] patterns [0:15];
		arst_n = 1'b0;
		text_color_we = 1'b0;
		text_color = 32'h0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		queued_cnt = 0;
		pred_color = 32'hFFFF_FFFF;
		for (int i = 0; i < 256; i++)
			gen_rows[i] = 16'h0;
		patterns = '{8'h00, 8'hFF, 8'h80, 8'h01, 8'hAA, 8'h55, 8'h18, 8'h7E,
			8'hC3, 8'h3C, 8'h0F, 8'hF0, 8'h81, 8'h42, 8'h24, 8'hFE};

		repeat (9)
			@(posedge clk);
		arst_n <= 1'b1;

		// directed, reset colour
		for (int row = 0; row < SLOT_ROWS; row++)
			queue_req(ACT_LOAD, 8'h41, 4'(row), patterns[row]);
		queue_req(ACT_PUT, 8'h41, 4'h0, 8'h00);
		queue_req(ACT_PUT, CODE_BACKSPACE, 4'h0, 8'h00);
		queue_req(ACT_PUT, CODE_BACKSPACE, 4'hF, 8'hFF);
		queue_req(ACT_PUT, CODE_NEWLINE, 4'h0, 8'h00);
		queue_req(ACT_PUT, 8'h41, 4'hF, 8'hFF);
		queue_req(ACT_HOME, 8'hFF, 4'hF, 8'hFF);
		queue_req(ACT_NONE, 8'hFF, 4'hF, 8'hFF);
		queue_req(ACT_PUT, 8'h41, 4'h0, 8'h00);
		wait_drained();

		// extreme codes, line wrap, rows off screen, row saturation
		write_color(32'h0000_0000);
		queue_glyph(8'h00);
		queue_glyph(8'hFF);
		queue_req(ACT_PUT, 8'h00, 4'h0, 8'h00);
		queue_req(ACT_PUT, 8'hFF, 4'h0, 8'h00);
		queue_req(ACT_HOME, 8'h00, 4'h0, 8'h00);
		repeat (COLUMNS + 2)
			queue_print();
		repeat (ROW_LIMIT + 3)
			queue_req(ACT_PUT, CODE_NEWLINE, 4'($urandom_range(15)), 8'($urandom_range(255)));
		queue_print();
		queue_req(ACT_PUT, CODE_BACKSPACE, 4'h0, 8'h00);
		queue_req(ACT_HOME, 8'h00, 4'h0, 8'h00);
		queue_print();
		wait_drained();

		write_color(32'($urandom));
		send_idle_pct = 83;
		queue_traffic(15);
		wait_drained();

		write_color(32'hFFFF_FFFF);
		send_idle_pct = 0;
		recv_stall_pct = 83;
		queue_traffic(20);
		wait_drained();

		write_color(32'($urandom));
		send_idle_pct = 26;
		recv_stall_pct = 26;
		queue_traffic(15);
		wait_drained();

		if (row_writes_q.size() != 0)
			$display("%0t: %0d row writes never arrived", $time, row_writes_q.size());
		if (error_cnt == 0 && row_writes_q.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

@@ files.f @@
+incdir+rtl
rtl/gtcr_pkg.sv
rtl/gtcr_in_if.sv
rtl/gtcr_out_if.sv
rtl/gtcr_front.sv
rtl/gtcr_fifo.sv
rtl/gtcr_back.sv
rtl/glyph_text_console_renderer.sv
tb/glyph_text_console_renderer_tb.sv
